// ----- rtl/core/numeric_expression_operand_splitter_assert.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the operand splitter
// Two concurrent assertion forms shared by the RTL of this block.
// ----------------------------------------------------------------------------
`ifndef NUMERIC_EXPRESSION_OPERAND_SPLITTER_ASSERT_SVH
`define NUMERIC_EXPRESSION_OPERAND_SPLITTER_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define NEOS_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define NEOS_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/core/neos_pkg.sv -----
// ----------------------------------------------------------------------------
// Operand splitter package
// Result codes, mode codes, register indexes, character codes and types.
// ----------------------------------------------------------------------------
package neos_pkg;

    typedef enum logic [1:0] {
        KIND_NONE   = 2'd0,
        KIND_SPLIT  = 2'd1,
        KIND_FINAL  = 2'd2,
        KIND_REJECT = 2'd3
    } kind_t;

    localparam logic [1:0] MODE_BASIC      = 2'd0;
    localparam logic [1:0] MODE_STANDARD   = 2'd1;
    localparam logic [1:0] MODE_SCIENTIFIC = 2'd2;
    localparam logic [1:0] MODE_PROGRAMMER = 2'd3;

    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_MODE         = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_OPERANDS = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_EXP      = 2'd2;

    localparam logic [1:0] MODE_RESET         = MODE_STANDARD;
    localparam logic [7:0] MAX_OPERANDS_RESET = 8'd100;
    localparam logic [3:0] MAX_EXP_RESET      = 4'd4;

    localparam logic [15:0] CH_0      = 16'h0030;
    localparam logic [15:0] CH_9      = 16'h0039;
    localparam logic [15:0] CH_PLUS   = 16'h002B;
    localparam logic [15:0] CH_MINUS  = 16'h002D;
    localparam logic [15:0] CH_DOT    = 16'h002E;
    localparam logic [15:0] CH_STAR   = 16'h002A;
    localparam logic [15:0] CH_SLASH  = 16'h002F;
    localparam logic [15:0] CH_LPAREN = 16'h0028;
    localparam logic [15:0] CH_RPAREN = 16'h0029;
    localparam logic [15:0] CH_CARET  = 16'h005E;
    localparam logic [15:0] CH_PCT    = 16'h0025;
    localparam logic [15:0] CH_LO_A   = 16'h0061;
    localparam logic [15:0] CH_LO_B   = 16'h0062;
    localparam logic [15:0] CH_LO_C   = 16'h0063;
    localparam logic [15:0] CH_LO_D   = 16'h0064;
    localparam logic [15:0] CH_LO_E   = 16'h0065;
    localparam logic [15:0] CH_LO_F   = 16'h0066;
    localparam logic [15:0] CH_UP_A   = 16'h0041;
    localparam logic [15:0] CH_UP_F   = 16'h0046;

    typedef struct packed {
        kind_t      kind;
        logic [8:0] beg_pos;
        logic [8:0] end_pos;
        logic [7:0] total;
        logic       last_flag;
    } result_t;

endpackage

// ----- rtl/core/numeric_expression_operand_splitter.sv -----
// ----------------------------------------------------------------------------
// Numeric expression operand splitter
// Splits a character stream into operand ranges at binary operators.
// ----------------------------------------------------------------------------
// Usage:
// The input channel (in_valid/in_ready) carries one word per character:
// char_code and is_last, which marks the final character of an expression.
// The output channel (out_valid/out_ready) carries result words: an operand
// closed at a split operator, the final operand on the last character, or a
// rejection of the whole expression. A character yields zero, one or two words.
// The configuration channel (cfg_valid/cfg_ready, always ready) writes mode,
// max_operands and max_exponent_digits by index; the user must use it only
// while idle (not enforced). A result word is valid in the cycle after its
// character is accepted. Throughput: one character per cycle while each yields
// at most one word; a character that yields two words (a split on the last
// character) holds the input until its first word leaves, since the output port
// drains one word a cycle. The two-entry result buffer sets that figure: a new
// character is taken when the buffer is empty or its only word leaves in the
// same cycle. Reset clears the expression state and the result buffer and loads
// the register defaults. When the receiver stalls, pending words hold unchanged
// and the input stalls once the buffer cannot take a new character's words.
// ----------------------------------------------------------------------------
module numeric_expression_operand_splitter #(
    parameter int MAX_LENGTH = 256
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [neos_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [7:0]                       cfg_data,
    input  logic                             in_valid,
    output logic                             in_ready,
    input  logic [15:0]                      char_code,
    input  logic                             is_last,
    output logic                             out_valid,
    input  logic                             out_ready,
    output logic [1:0]                       kind,
    output logic [8:0]                       operand_begin,
    output logic [8:0]                       operand_end,
    output logic [7:0]                       operand_total,
    output logic                             final_flag
);

    // Wide enough to hold one past the saturated position.
    localparam int POS_W = $clog2(MAX_LENGTH + 2);
    localparam logic [POS_W-1:0] POS_MAX = POS_W'(MAX_LENGTH);

    // Configuration registers.
    logic [1:0] mode_reg;
    logic [7:0] max_ops_reg;
    logic [3:0] max_exp_reg;

    // Expression state.
    logic [POS_W-1:0] pos_reg,   pos_next;
    logic [POS_W-1:0] start_reg, start_next;
    logic [7:0]       count_reg, count_next;
    logic [3:0]       exp_reg,   exp_next;
    logic             cexp_reg,  cexp_next;
    logic             atstart_reg, atstart_next;
    logic             paren_reg, paren_next;
    logic             prevop_reg, prevop_next;
    logic             preve_reg, preve_next;
    logic             rej_reg,   rej_next;

    // Result buffer: slot 0 is presented on the output port.
    neos_pkg::result_t slot0_reg, slot0_next;
    neos_pkg::result_t slot1_reg, slot1_next;
    logic [1:0]        cnt_reg,   cnt_next;

    // Per-character decode and results.
    logic              is_digit, is_plus_minus, is_op, valid_char;
    logic              split, act;
    logic [4:0]        exp_inc;
    logic [7:0]        count_split;
    neos_pkg::result_t split_res, final_res, new0, new1;
    logic [1:0]        new_cnt;
    logic              in_fire, out_fire;

    assign cfg_ready = 1'b1;
    assign out_valid = (cnt_reg != 2'd0);
    assign in_ready  = (cnt_reg == 2'd0) || ((cnt_reg == 2'd1) && out_ready);
    assign in_fire   = in_valid && in_ready;
    assign out_fire  = out_valid && out_ready;

    assign kind          = slot0_reg.kind;
    assign operand_begin = slot0_reg.beg_pos;
    assign operand_end   = slot0_reg.end_pos;
    assign operand_total = slot0_reg.total;
    assign final_flag    = slot0_reg.last_flag;

    // Character classes for the current mode.
    always_comb
    begin
        logic basic_set, std_set, sci_set, prog_set;
        is_digit      = (char_code >= neos_pkg::CH_0) && (char_code <= neos_pkg::CH_9);
        is_plus_minus = (char_code == neos_pkg::CH_PLUS) || (char_code == neos_pkg::CH_MINUS);
        is_op         = is_plus_minus || (char_code == neos_pkg::CH_STAR)
                        || (char_code == neos_pkg::CH_SLASH) || (char_code == neos_pkg::CH_CARET)
                        || (char_code == neos_pkg::CH_PCT);
        basic_set = is_digit || is_plus_minus || (char_code == neos_pkg::CH_DOT)
                    || (char_code == neos_pkg::CH_LO_E);
        std_set   = (char_code == neos_pkg::CH_STAR) || (char_code == neos_pkg::CH_SLASH);
        sci_set   = (char_code == neos_pkg::CH_LPAREN) || (char_code == neos_pkg::CH_RPAREN)
                    || (char_code == neos_pkg::CH_CARET) || (char_code == neos_pkg::CH_PCT);
        prog_set  = (char_code == neos_pkg::CH_LPAREN) || (char_code == neos_pkg::CH_RPAREN)
                    || (char_code == neos_pkg::CH_PCT)
                    || ((char_code >= neos_pkg::CH_LO_A) && (char_code <= neos_pkg::CH_LO_D))
                    || (char_code == neos_pkg::CH_LO_F)
                    || ((char_code >= neos_pkg::CH_UP_A) && (char_code <= neos_pkg::CH_UP_F));
        valid_char = basic_set
                     || ((mode_reg != neos_pkg::MODE_BASIC) && std_set)
                     || ((mode_reg == neos_pkg::MODE_SCIENTIFIC) && sci_set)
                     || ((mode_reg == neos_pkg::MODE_PROGRAMMER) && prog_set);
    end

    // Next expression state for the character on the input port.
    always_comb
    begin
        logic sign, skip_tail;
        sign         = 1'b0;
        skip_tail    = 1'b0;
        split        = 1'b0;
        pos_next     = pos_reg;
        start_next   = start_reg;
        count_next   = count_reg;
        exp_next     = exp_reg;
        cexp_next    = cexp_reg;
        atstart_next = atstart_reg;
        paren_next   = paren_reg;
        prevop_next  = prevop_reg;
        preve_next   = preve_reg;
        rej_next     = rej_reg;
        exp_inc      = {1'b0, exp_reg} + 5'd1;
        count_split  = count_reg + 8'd1;
        act          = !rej_reg && valid_char;

        if (act)
        begin
            priority if (count_reg >= max_ops_reg)
            begin
                rej_next = 1'b1;
            end
            else if (is_digit)
            begin
                if (cexp_reg)
                begin
                    if (exp_inc > {1'b0, max_exp_reg})
                        rej_next = 1'b1;
                    else
                        exp_next = exp_inc[3:0];
                end
                prevop_next = 1'b0;
            end
            else if (char_code == neos_pkg::CH_LO_E)
            begin
                if (mode_reg != neos_pkg::MODE_PROGRAMMER)
                    cexp_next = 1'b1;
                prevop_next = 1'b0;
            end
            else if (is_op)
            begin
                // A plus or minus in a sign position does not split.
                sign = is_plus_minus
                       && (paren_reg || atstart_reg || prevop_reg
                           || ((mode_reg != neos_pkg::MODE_PROGRAMMER)
                               && ((pos_reg == '0) || preve_reg)));
                if (sign)
                begin
                    prevop_next = 1'b0;
                    skip_tail   = 1'b1;
                end
                else
                begin
                    split       = 1'b1;
                    cexp_next   = 1'b0;
                    exp_next    = 4'd0;
                    prevop_next = 1'b1;
                    count_next  = count_split;
                    start_next  = pos_reg + POS_W'(1);
                end
            end
            else
            begin
                prevop_next = 1'b0;
            end

            if (!rej_next && !skip_tail)
            begin
                paren_next   = (char_code == neos_pkg::CH_LPAREN);
                atstart_next = 1'b0;
            end
        end

        preve_next = (char_code == neos_pkg::CH_LO_E);
        pos_next   = (pos_reg < POS_MAX) ? pos_reg + POS_W'(1) : POS_MAX;

        split_res.kind      = neos_pkg::KIND_SPLIT;
        split_res.beg_pos   = 9'(start_reg);
        split_res.end_pos   = 9'(pos_reg);
        split_res.total     = count_split;
        split_res.last_flag = 1'b0;

        final_res.kind      = neos_pkg::KIND_FINAL;
        final_res.beg_pos   = 9'(start_next);
        final_res.end_pos   = 9'(pos_next);
        final_res.total     = (count_next != 8'hFF) ? count_next + 8'd1 : 8'hFF;
        final_res.last_flag = 1'b1;

        new0    = split_res;
        new1    = final_res;
        new_cnt = 2'd0;
        if (is_last)
        begin
            if (rej_next)
            begin
                new0.kind      = neos_pkg::KIND_REJECT;
                new0.beg_pos   = 9'd0;
                new0.end_pos   = 9'd0;
                new0.total     = 8'd0;
                new0.last_flag = 1'b1;
                new_cnt        = 2'd1;
            end
            else if (split)
            begin
                new_cnt = 2'd2;
            end
            else
            begin
                new0    = final_res;
                new_cnt = 2'd1;
            end

            // The expression ends here: back to the start-of-expression state.
            pos_next     = '0;
            start_next   = '0;
            count_next   = 8'd0;
            exp_next     = 4'd0;
            cexp_next    = 1'b0;
            atstart_next = 1'b1;
            paren_next   = 1'b0;
            prevop_next  = 1'b0;
            preve_next   = 1'b0;
            rej_next     = 1'b0;
        end
        else if (split)
        begin
            new_cnt = 2'd1;
        end
    end

    // Result buffer control. A new character is only taken once the buffer
    // is empty or drains in this cycle, so its words always load from slot 0.
    always_comb
    begin
        slot0_next = slot0_reg;
        slot1_next = slot1_reg;
        cnt_next   = cnt_reg;
        if (in_fire)
        begin
            slot0_next = new0;
            slot1_next = new1;
            cnt_next   = new_cnt;
        end
        else if (out_fire)
        begin
            slot0_next = slot1_reg;
            cnt_next   = cnt_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg    <= neos_pkg::MODE_RESET;
            max_ops_reg <= neos_pkg::MAX_OPERANDS_RESET;
            max_exp_reg <= neos_pkg::MAX_EXP_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                neos_pkg::CFG_MODE:         mode_reg    <= cfg_data[1:0];
                neos_pkg::CFG_MAX_OPERANDS: max_ops_reg <= cfg_data;
                neos_pkg::CFG_MAX_EXP:      max_exp_reg <= cfg_data[3:0];
                default:                    ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg     <= '0;
            start_reg   <= '0;
            count_reg   <= 8'd0;
            exp_reg     <= 4'd0;
            cexp_reg    <= 1'b0;
            atstart_reg <= 1'b1;
            paren_reg   <= 1'b0;
            prevop_reg  <= 1'b0;
            preve_reg   <= 1'b0;
            rej_reg     <= 1'b0;
            cnt_reg     <= 2'd0;
        end
        else
        begin
            if (in_fire)
            begin
                pos_reg     <= pos_next;
                start_reg   <= start_next;
                count_reg   <= count_next;
                exp_reg     <= exp_next;
                cexp_reg    <= cexp_next;
                atstart_reg <= atstart_next;
                paren_reg   <= paren_next;
                prevop_reg  <= prevop_next;
                preve_reg   <= preve_next;
                rej_reg     <= rej_next;
            end
            cnt_reg <= cnt_next;
        end
    end

    // Result payload needs no reset; out_valid qualifies it.
    always_ff @(posedge clk)
    begin
        slot0_reg <= slot0_next;
        slot1_reg <= slot1_next;
    end

`include "numeric_expression_operand_splitter_assert.svh"

    // The buffer holds at most the two words of one character.
    `NEOS_ASSERT_IMP(a_cnt_range, clk, rst_n, 1'b1, cnt_reg != 2'd3, "result buffer overflow")

    // With two words pending, the split word goes out ahead of the final one.
    `NEOS_ASSERT_IMP(a_pair_order, clk, rst_n, cnt_reg == 2'd2,
        (slot0_reg.kind == neos_pkg::KIND_SPLIT) && (slot1_reg.kind == neos_pkg::KIND_FINAL),
        "two pending words out of order")

    // Closing words carry the final flag, split words never do.
    `NEOS_ASSERT_IMP(a_final_flag, clk, rst_n, out_valid,
        final_flag == (slot0_reg.kind != neos_pkg::KIND_SPLIT), "final flag mismatch")

    // The last character returns the expression to its start state.
    `NEOS_ASSERT_NXT(a_expr_clear, clk, rst_n, in_fire && is_last,
        (pos_reg == '0) && !rej_reg && atstart_reg && (count_reg == 8'd0),
        "expression state not cleared after last character")

endmodule
